// ===== sv/nfsacct_pkg.sv =====
// nfsacct_pkg: shared types, codes and constants for the per-host nfs accounting table
// holds the entry and token structs passed along the cell chain and the rpc call classifier
// no dependencies
`timescale 1ns / 1ps

package nfsacct_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int BYTE_W   = 48;
  localparam int CNT_W32  = 32;
  localparam int FRAME_W  = 16;
  localparam int OUTPOS_W = 6;
  // position / fill count width covering the largest supported table
  localparam int POS_W    = 11;

  localparam int TABLE_ENTRIES_DEF = 64;

  // rpc call match constants
  localparam logic [31:0] NFS_PROGRAM     = 32'd100003;
  localparam logic [31:0] RPC_VERSION_TWO = 32'd2;
  localparam logic [31:0] RPC_CALL        = 32'd0;
  localparam logic [15:0] MIN_PAYLOAD     = 16'd28;
  localparam logic [31:0] PROC_LIMIT      = 32'd22;

  // saturation limits
  localparam logic [BYTE_W-1:0]  BYTE_MAX = {BYTE_W{1'b1}};
  localparam logic [CNT_W32-1:0] CNT_MAX  = {CNT_W32{1'b1}};

  // result status codes
  typedef enum logic [1:0] {
    ST_UPDATE = 2'd0,
    ST_INSERT = 2'd1,
    ST_DROP   = 2'd2,
    ST_READ   = 2'd3
  } status_t;

  // what the traveling token is doing
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SHIFT  = 2'd1,
    PH_PASS   = 2'd2,
    PH_READ   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  bytes;
    logic [CNT_W32-1:0] pkts;
    logic [CNT_W32-1:0] ops;
  } entry_t;

  // one transaction moving down the chain, one cell per cycle
  typedef struct packed {
    logic                act;
    phase_t              phase;
    logic                full;
    logic                nfs;
    logic [ADDR_W-1:0]   peer;
    logic [FRAME_W-1:0]  frame;
    logic [OUTPOS_W-1:0] target;
    logic [POS_W-1:0]    rem;
    entry_t              carry;
    status_t             status;
    logic [OUTPOS_W-1:0] res_pos;
    logic                res_valid;
    entry_t              res;
  } tok_t;

  // nfs call detection on the decoded rpc header
  function automatic logic classify(input logic [15:0] payload_len,
                                    input logic [31:0] msg_type,
                                    input logic [31:0] version,
                                    input logic [31:0] prog_num,
                                    input logic [31:0] procedure);
    logic ok;
    ok = (payload_len > MIN_PAYLOAD) && (msg_type == RPC_CALL) &&
         (version == RPC_VERSION_TWO) && (prog_num == NFS_PROGRAM) &&
         (procedure != 32'd0) && (procedure < PROC_LIMIT);
    return ok;
  endfunction

endpackage

// ===== sv/nfsacct_cell.sv =====
// nfsacct_cell: one table position of the sorted peer chain
// holds one entry, updates / inserts / shifts it as the token passes, registers the token onward
// depends on nfsacct_pkg
`timescale 1ns / 1ps

module nfsacct_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nfsacct_pkg::tok_t  tok_in,
  output nfsacct_pkg::tok_t  tok_out
);

  localparam logic [nfsacct_pkg::POS_W-1:0] IDX = nfsacct_pkg::POS_W'(CELL_IDX);

  nfsacct_pkg::entry_t entry_r, entry_nxt;
  nfsacct_pkg::tok_t   tok_r, tok_nxt;

  logic                              here_valid;
  logic [nfsacct_pkg::BYTE_W:0]      byte_sum;
  nfsacct_pkg::entry_t               upd;
  nfsacct_pkg::entry_t               newe;

  // saturating update of the held entry
  always_comb begin
    byte_sum  = {1'b0, entry_r.bytes} +
                (nfsacct_pkg::BYTE_W + 1)'(tok_in.frame);
    upd       = entry_r;
    upd.bytes = byte_sum[nfsacct_pkg::BYTE_W] ? nfsacct_pkg::BYTE_MAX :
                byte_sum[nfsacct_pkg::BYTE_W-1:0];
    if (entry_r.pkts != nfsacct_pkg::CNT_MAX) begin
      upd.pkts = entry_r.pkts + 32'd1;
    end
    if (tok_in.nfs && (entry_r.ops != nfsacct_pkg::CNT_MAX)) begin
      upd.ops = entry_r.ops + 32'd1;
    end
  end

  // fresh entry for a new peer
  always_comb begin
    newe.addr  = tok_in.peer;
    newe.bytes = nfsacct_pkg::BYTE_W'(tok_in.frame);
    newe.pkts  = 32'd1;
    newe.ops   = {31'd0, tok_in.nfs};
  end

  // token step at this position
  always_comb begin
    entry_nxt  = entry_r;
    tok_nxt    = tok_in;
    here_valid = (tok_in.rem != '0);
    tok_nxt.rem = tok_in.rem - nfsacct_pkg::POS_W'(here_valid);
    if (tok_in.act) begin
      case (tok_in.phase)
        nfsacct_pkg::PH_READ: begin
          if (here_valid && (IDX == nfsacct_pkg::POS_W'(tok_in.target))) begin
            tok_nxt.res_valid = 1'b1;
            tok_nxt.res       = entry_r;
          end
        end
        nfsacct_pkg::PH_SEARCH: begin
          if (here_valid && (entry_r.addr > tok_in.peer)) begin
            // keep walking
          end else if (here_valid && (entry_r.addr == tok_in.peer)) begin
            entry_nxt         = upd;
            tok_nxt.status    = nfsacct_pkg::ST_UPDATE;
            tok_nxt.res_pos   = IDX[nfsacct_pkg::OUTPOS_W-1:0];
            tok_nxt.res_valid = 1'b1;
            tok_nxt.res       = upd;
            tok_nxt.phase     = nfsacct_pkg::PH_PASS;
          end else if (tok_in.full) begin
            // peer absent and no room: drop result already preset
            tok_nxt.phase = nfsacct_pkg::PH_PASS;
          end else begin
            entry_nxt         = newe;
            tok_nxt.status    = nfsacct_pkg::ST_INSERT;
            tok_nxt.res_pos   = IDX[nfsacct_pkg::OUTPOS_W-1:0];
            tok_nxt.res_valid = 1'b1;
            tok_nxt.res       = newe;
            tok_nxt.carry     = entry_r;
            tok_nxt.phase     = here_valid ? nfsacct_pkg::PH_SHIFT : nfsacct_pkg::PH_PASS;
          end
        end
        nfsacct_pkg::PH_SHIFT: begin
          // displaced entry moves down one place
          entry_nxt     = tok_in.carry;
          tok_nxt.carry = entry_r;
          if (!here_valid) begin
            tok_nxt.phase = nfsacct_pkg::PH_PASS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry storage, token register
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== sv/per_host_nfs_traffic_accounting.sv =====
// per_host_nfs_traffic_accounting: sorted per-peer byte / packet / nfs call counter table
// the accepted token is registered at injection and then in every cell before out_strobe
// one transaction at a time: busy stays high until the result appears
// the result strobe lasts one cycle and the receiver cannot stall it
// reset (rst_n low, synchronous) empties the table and clears local_address; entries not cleared
// depends on nfsacct_pkg and nfsacct_cell
`timescale 1ns / 1ps

module per_host_nfs_traffic_accounting #(
  parameter int TABLE_ENTRIES = nfsacct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_destination_address,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_rpc_message_type,
  input  logic [31:0] in_rpc_version,
  input  logic [31:0] in_rpc_program,
  input  logic [31:0] in_rpc_procedure,
  input  logic [5:0]  in_read_position,
  // result channel
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_position,
  output logic        out_entry_valid,
  output logic [31:0] out_peer_address_out,
  output logic [47:0] out_byte_total,
  output logic [31:0] out_packet_total,
  output logic [31:0] out_operation_total,
  output logic        out_is_nfs_operation,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  nfsacct_pkg::tok_t chain [TABLE_ENTRIES+1];
  nfsacct_pkg::tok_t inj_r, inj_nxt;
  nfsacct_pkg::tok_t tail;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [31:0]       local_addr_r, local_addr_nxt;
  logic              accept;
  logic              nfs;

  assign tail   = chain[TABLE_ENTRIES];
  assign busy   = busy_r && !tail.act;
  assign accept = start && !busy;

  // configuration register
  assign cfg_ready      = 1'b1;
  assign local_addr_nxt = cfg_valid ? cfg_data : local_addr_r;

  // fill count follows completed inserts
  assign used_nxt = used_r +
                    CNT_W'(tail.act && (tail.status == nfsacct_pkg::ST_INSERT));

  // busy from accept until the result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail.act) begin
      busy_nxt = 1'b0;
    end
  end

  assign nfs = nfsacct_pkg::classify(in_payload_length, in_rpc_message_type, in_rpc_version,
                                     in_rpc_program, in_rpc_procedure);

  // token built from the accepted transaction
  always_comb begin
    inj_nxt           = '0;
    inj_nxt.act       = accept;
    inj_nxt.full      = (used_nxt == CNT_W'(TABLE_ENTRIES));
    inj_nxt.rem       = nfsacct_pkg::POS_W'(used_nxt);
    inj_nxt.frame     = in_frame_length;
    inj_nxt.target    = in_read_position;
    inj_nxt.peer      = (in_source_address == local_addr_r) ? in_destination_address
                                                             : in_source_address;
    if (in_mode) begin
      inj_nxt.phase   = nfsacct_pkg::PH_READ;
      inj_nxt.status  = nfsacct_pkg::ST_READ;
      inj_nxt.res_pos = in_read_position;
      inj_nxt.nfs     = 1'b0;
    end else begin
      inj_nxt.phase   = nfsacct_pkg::PH_SEARCH;
      inj_nxt.status  = nfsacct_pkg::ST_DROP;
      inj_nxt.nfs     = nfs;
    end
  end

  // control and injection registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      used_r       <= '0;
      local_addr_r <= '0;
      inj_r        <= '0;
    end else begin
      busy_r       <= busy_nxt;
      used_r       <= used_nxt;
      local_addr_r <= local_addr_nxt;
      inj_r        <= inj_nxt;
    end
  end

  assign chain[0] = inj_r;

  // row of table cells, position 0 holds the highest address
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    nfsacct_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  // result ports from the end of the chain
  assign out_strobe           = tail.act;
  assign out_status           = tail.status;
  assign out_entry_position   = tail.res_pos;
  assign out_entry_valid      = tail.res_valid;
  assign out_peer_address_out = tail.res.addr;
  assign out_byte_total       = tail.res.bytes;
  assign out_packet_total     = tail.res.pkts;
  assign out_operation_total  = tail.res.ops;
  assign out_is_nfs_operation = tail.nfs;

endmodule
